// ===== rtl/aabb_axis_collision_resolve_defines.svh =====
// Assertion macros for the collision resolver checker.
// Needs clk_i and rst_ni in the scope of use.
`ifndef AABB_AXIS_COLLISION_RESOLVE_DEFINES_SVH
`define AABB_AXIS_COLLISION_RESOLVE_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define AACR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define AACR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/aacr_pkg.sv =====
// Shared types, constants and arithmetic helpers of the collision resolver.
// No dependencies.
package aacr_pkg;

  localparam int CoordBits = 24;
  localparam int HalfBits  = 23;
  localparam int WideBits  = 27;
  localparam int FtBits    = 16;
  localparam int CntBits   = 7;
  localparam int CfgIdxBits = 3;
  localparam int ProdBits  = CoordBits + FtBits + 1;
  localparam int GroundTol = 5;

  localparam logic [1:0] ModeWall  = 2'd0;
  localparam logic [1:0] ModePlace = 2'd1;
  localparam logic [1:0] ModeStep  = 2'd2;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic [CfgIdxBits-1:0] CfgHalfX     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgHalfY     = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgHalfZ     = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgWallCount = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgStartX    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgStartY    = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgStartZ    = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgFrameTime = 3'd7;

  localparam logic [HalfBits-1:0] HalfXReset = 23'd128;
  localparam logic [HalfBits-1:0] HalfYReset = 23'd256;
  localparam logic [HalfBits-1:0] HalfZReset = 23'd128;
  localparam logic [FtBits-1:0]   FrameTimeReset = 16'd1092;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [HalfBits-1:0] half_t;

  typedef struct packed {
    coord_t cx;
    half_t  hx;
    coord_t cy;
    half_t  hy;
    coord_t cz;
    half_t  hz;
  } wall_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] wall_index;
    wall_t      wall;
    coord_t     vel_x;
    coord_t     vel_y;
    coord_t     vel_z;
  } item_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       add;
    logic       rd_en;
    logic       eval;
    logic       geval;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic gnd;
  } stat_t;

  function automatic coord_t sat_coord(input logic signed [WideBits-1:0] v);
    logic signed [WideBits-1:0] hi;
    logic signed [WideBits-1:0] lo;
    hi = WideBits'(signed'({1'b0, {(CoordBits-1){1'b1}}}));
    lo = -hi - WideBits'(signed'(2'sb01));
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  // |p - c| < bh + wh, exact
  function automatic logic overlap(input coord_t p, input coord_t c,
                                   input half_t bh, input half_t wh);
    logic signed [CoordBits:0] d;
    logic [CoordBits:0] a;
    logic [HalfBits:0] s;
    d = {p[CoordBits-1], p} - {c[CoordBits-1], c};
    a = d[CoordBits] ? (CoordBits+1)'(-d) : (CoordBits+1)'(d);
    s = {1'b0, bh} + {1'b0, wh};
    return a < {1'b0, s};
  endfunction

endpackage

// ===== rtl/aacr_if.sv =====
// Channel interfaces of the collision resolver: item in, result out, config.
// Depends on aacr_pkg.
interface aacr_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [5:0]       wall_index;
  aacr_pkg::coord_t wall_center_x;
  aacr_pkg::coord_t wall_center_y;
  aacr_pkg::coord_t wall_center_z;
  aacr_pkg::half_t  wall_half_x;
  aacr_pkg::half_t  wall_half_y;
  aacr_pkg::half_t  wall_half_z;
  aacr_pkg::coord_t vel_x;
  aacr_pkg::coord_t vel_y;
  aacr_pkg::coord_t vel_z;
  modport source (output valid, mode, wall_index, wall_center_x, wall_center_y,
                  wall_center_z, wall_half_x, wall_half_y, wall_half_z,
                  vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, mode, wall_index, wall_center_x, wall_center_y,
                wall_center_z, wall_half_x, wall_half_y, wall_half_z,
                vel_x, vel_y, vel_z, output ready);
endinterface

interface aacr_out_if;
  logic             valid;
  logic             ready;
  aacr_pkg::coord_t pos_x;
  aacr_pkg::coord_t pos_y;
  aacr_pkg::coord_t pos_z;
  aacr_pkg::coord_t out_vel_x;
  aacr_pkg::coord_t out_vel_y;
  aacr_pkg::coord_t out_vel_z;
  logic             grounded;
  modport source (output valid, pos_x, pos_y, pos_z, out_vel_x, out_vel_y,
                  out_vel_z, grounded, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, out_vel_x, out_vel_y,
                out_vel_z, grounded, output ready);
endinterface

interface aacr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [aacr_pkg::CfgIdxBits-1:0]     index;
  logic [aacr_pkg::CoordBits-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/aacr_ctrl.sv =====
// Sequencer of the collision resolver: per-axis move, wall scans, ground scan.
// Depends on aacr_pkg.
module aacr_ctrl #(
  parameter int MAX_WALLS = 64,
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_mode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [CW-1:0]       scan_len_i,
  input  aacr_pkg::stat_t     stat_i,
  output aacr_pkg::cmd_t      cmd_o,
  output logic [AW-1:0]       rd_addr_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SMul   = 3'd1;
  localparam logic [2:0] SAdd   = 3'd2;
  localparam logic [2:0] SScan  = 3'd3;
  localparam logic [2:0] SGScan = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [1:0]    axis_q, axis_d;
  logic [CW-1:0] ra_q, ra_d;
  logic          ev_q, ev_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;
  logic          scanning, rd_en, rd_last, finish;

  assign scanning = (state_q == SScan) || (state_q == SGScan);
  assign rd_en    = scanning && (ra_q < scan_len_i);
  assign rd_last  = rd_en && (((CW+1)'(ra_q) + (CW+1)'(1)) == (CW+1)'(scan_len_i));
  assign finish   = last_q || (scan_len_i == '0);
  assign rd_addr_o = ra_q[AW-1:0];
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    ra_d    = ra_q;
    ev_d    = 1'b0;
    last_d  = 1'b0;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    cmd_o.axis  = axis_q;
    cmd_o.rd_en = rd_en;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d = aacr_pkg::AxisX;
          state_d = (in_mode_i == aacr_pkg::ModeStep) ? SMul : SDone;
        end
      end
      SMul: begin
        cmd_o.mul = 1'b1;
        state_d = SAdd;
      end
      SAdd: begin
        cmd_o.add = 1'b1;
        ra_d = '0;
        state_d = SScan;
      end
      SScan: begin
        cmd_o.eval = ev_q;
        if (rd_en) ra_d = ra_q + CW'(1);
        ev_d = rd_en;
        last_d = rd_last;
        if (finish) begin
          ra_d = '0;
          ev_d = 1'b0;
          last_d = 1'b0;
          if (axis_q == aacr_pkg::AxisZ) begin
            state_d = SGScan;
          end else begin
            axis_d = axis_q + 2'd1;
            state_d = SMul;
          end
        end
      end
      SGScan: begin
        cmd_o.geval = ev_q;
        if (rd_en) ra_d = ra_q + CW'(1);
        ev_d = rd_en;
        last_d = rd_last;
        if (stat_i.gnd || finish) begin
          ev_d = 1'b0;
          last_d = 1'b0;
          state_d = SDone;
        end
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      axis_q  <= aacr_pkg::AxisX;
      ra_q    <= '0;
      ev_q    <= 1'b0;
      last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      ra_q    <= ra_d;
      ev_q    <= ev_d;
      last_q  <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/aacr_dp.sv =====
// Datapath of the collision resolver: config registers, wall memory,
// box state, move multiplier, push and ground evaluation. Depends on aacr_pkg.
module aacr_dp #(
  parameter int MAX_WALLS = 64,
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [aacr_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [aacr_pkg::CoordBits-1:0]     cfg_data_i,
  input  aacr_pkg::item_t                    item_i,
  input  aacr_pkg::cmd_t                     cmd_i,
  input  logic [AW-1:0]                      rd_addr_i,
  output logic [CW-1:0]                      scan_len_o,
  output aacr_pkg::stat_t                    stat_o,
  output aacr_pkg::coord_t                   pos_o [3],
  output aacr_pkg::coord_t                   vel_o [3],
  output logic                               gnd_o
);

  localparam int WB = aacr_pkg::WideBits;

  aacr_pkg::half_t  half_q [3];
  logic [aacr_pkg::CntBits-1:0] wall_count_q;
  aacr_pkg::coord_t start_q [3];
  logic [aacr_pkg::FtBits-1:0] ft_q;

  aacr_pkg::coord_t pos_q [3];
  aacr_pkg::coord_t prev_q [3];
  aacr_pkg::coord_t vel_q [3];
  logic             gnd_q, mv_pos_q, mv_zero_q;
  logic signed [aacr_pkg::ProdBits-1:0] prod_q;

  aacr_pkg::wall_t  mem_q [MAX_WALLS];
  aacr_pkg::wall_t  rdata_q;

  aacr_pkg::coord_t out_pos_q [3];
  aacr_pkg::coord_t out_vel_q [3];
  logic             out_gnd_q;

  // per-axis selections
  aacr_pkg::coord_t pos_a, prev_a, vel_a, cw_a, new_p, push_p;
  aacr_pkg::half_t  hw_a, bh_a;
  logic             ov_x, ov_y, ov_z, ov_prev_a, ov_test, ov_prev, hit, push_up;
  logic signed [WB-1:0] lowf, highf, np, bottom, top;
  logic             in_band, gnd_hit;
  int unsigned      scan_len_int;

  assign scan_len_int = (32'(wall_count_q) > 32'(MAX_WALLS)) ? 32'(MAX_WALLS)
                                                              : 32'(wall_count_q);
  assign scan_len_o = CW'(scan_len_int);
  assign stat_o.gnd = gnd_q;

  always_comb begin
    case (cmd_i.axis)
      aacr_pkg::AxisY: begin
        pos_a = pos_q[1]; prev_a = prev_q[1]; vel_a = vel_q[1];
        cw_a = rdata_q.cy; hw_a = rdata_q.hy; bh_a = half_q[1];
      end
      aacr_pkg::AxisZ: begin
        pos_a = pos_q[2]; prev_a = prev_q[2]; vel_a = vel_q[2];
        cw_a = rdata_q.cz; hw_a = rdata_q.hz; bh_a = half_q[2];
      end
      default: begin
        pos_a = pos_q[0]; prev_a = prev_q[0]; vel_a = vel_q[0];
        cw_a = rdata_q.cx; hw_a = rdata_q.hx; bh_a = half_q[0];
      end
    endcase
  end

  // move: floor(vel * ft / 65536), arithmetic shift floors
  always_comb begin
    logic signed [WB-1:0] disp;
    disp  = WB'(prod_q >>> aacr_pkg::FtBits);
    new_p = aacr_pkg::sat_coord(WB'(pos_a) + disp);
  end

  // wall test; off-axis coordinates of the test box equal the old ones
  always_comb begin
    ov_x = aacr_pkg::overlap(pos_q[0], rdata_q.cx, half_q[0], rdata_q.hx);
    ov_y = aacr_pkg::overlap(pos_q[1], rdata_q.cy, half_q[1], rdata_q.hy);
    ov_z = aacr_pkg::overlap(pos_q[2], rdata_q.cz, half_q[2], rdata_q.hz);
    ov_prev_a = aacr_pkg::overlap(prev_a, cw_a, bh_a, hw_a);
    ov_test = ov_x && ov_y && ov_z;
    case (cmd_i.axis)
      aacr_pkg::AxisY: ov_prev = ov_x && ov_prev_a && ov_z;
      aacr_pkg::AxisZ: ov_prev = ov_x && ov_y && ov_prev_a;
      default:         ov_prev = ov_prev_a && ov_y && ov_z;
    endcase
    hit = ov_test && !(mv_zero_q && ov_prev);
    lowf  = WB'(cw_a) - WB'({1'b0, hw_a}) - WB'({1'b0, bh_a});
    highf = WB'(cw_a) + WB'({1'b0, hw_a}) + WB'({1'b0, bh_a});
    push_up = 1'b0;
    if (mv_pos_q) begin
      np = lowf;
    end else if (!mv_zero_q || (cmd_i.axis == aacr_pkg::AxisY)) begin
      np = highf;
      push_up = (cmd_i.axis == aacr_pkg::AxisY);
    end else begin
      np = (prev_a < cw_a) ? lowf : highf;
    end
    push_p = aacr_pkg::sat_coord(np);
  end

  // ground contact within the tolerance band of the wall top
  always_comb begin
    bottom = WB'(pos_q[1]) - WB'({1'b0, half_q[1]});
    top    = WB'(rdata_q.cy) + WB'({1'b0, rdata_q.hy});
    in_band = (bottom >= top - WB'(aacr_pkg::GroundTol)) &&
              (bottom <= top + WB'(aacr_pkg::GroundTol));
    gnd_hit = in_band && ov_x && ov_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= aacr_pkg::HalfXReset;
      half_q[1] <= aacr_pkg::HalfYReset;
      half_q[2] <= aacr_pkg::HalfZReset;
      wall_count_q <= '0;
      start_q[0] <= '0;
      start_q[1] <= '0;
      start_q[2] <= '0;
      ft_q <= aacr_pkg::FrameTimeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        aacr_pkg::CfgHalfX:     half_q[0] <= cfg_data_i[aacr_pkg::HalfBits-1:0];
        aacr_pkg::CfgHalfY:     half_q[1] <= cfg_data_i[aacr_pkg::HalfBits-1:0];
        aacr_pkg::CfgHalfZ:     half_q[2] <= cfg_data_i[aacr_pkg::HalfBits-1:0];
        aacr_pkg::CfgWallCount: wall_count_q <= cfg_data_i[aacr_pkg::CntBits-1:0];
        aacr_pkg::CfgStartX:    start_q[0] <= cfg_data_i;
        aacr_pkg::CfgStartY:    start_q[1] <= cfg_data_i;
        aacr_pkg::CfgStartZ:    start_q[2] <= cfg_data_i;
        aacr_pkg::CfgFrameTime: ft_q <= cfg_data_i[aacr_pkg::FtBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      gnd_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        gnd_q <= 1'b0;
        if (item_i.mode == aacr_pkg::ModePlace) begin
          pos_q[0] <= start_q[0];
          pos_q[1] <= start_q[1];
          pos_q[2] <= start_q[2];
        end
      end
      if (cmd_i.add) pos_q[cmd_i.axis] <= new_p;
      if (cmd_i.eval && hit) begin
        pos_q[cmd_i.axis] <= push_p;
        if (push_up) gnd_q <= 1'b1;
      end
      if (cmd_i.geval && gnd_hit) gnd_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (item_i.mode == aacr_pkg::ModeStep) begin
        vel_q[0] <= item_i.vel_x;
        vel_q[1] <= item_i.vel_y;
        vel_q[2] <= item_i.vel_z;
      end else begin
        vel_q[0] <= '0;
        vel_q[1] <= '0;
        vel_q[2] <= '0;
      end
    end
    if (cmd_i.eval && hit) vel_q[cmd_i.axis] <= '0;
    if (cmd_i.mul) begin
      prev_q <= pos_q;
      prod_q <= aacr_pkg::ProdBits'(vel_a) * aacr_pkg::ProdBits'(signed'({1'b0, ft_q}));
    end
    if (cmd_i.add) begin
      mv_zero_q <= (new_p == pos_a);
      mv_pos_q  <= (new_p > pos_a);
    end
    if (cmd_i.out_load) begin
      out_pos_q <= pos_q;
      out_vel_q <= vel_q;
      out_gnd_q <= gnd_q;
    end
  end

  // wall table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (item_i.mode == aacr_pkg::ModeWall) &&
        (32'(item_i.wall_index) < 32'(MAX_WALLS))) begin
      mem_q[AW'(item_i.wall_index)] <= item_i.wall;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= mem_q[rd_addr_i];
  end

  assign pos_o = out_pos_q;
  assign vel_o = out_vel_q;
  assign gnd_o = out_gnd_q;

endmodule

// ===== rtl/aabb_axis_collision_resolve.sv =====
// Top level of the moving-box collision resolver.
// Depends on aacr_pkg, aacr_if, aacr_ctrl and aacr_dp.

// One item in, one result out. Mode 0 writes a wall into the table, mode 1
// places the box at the start registers, mode 2 runs a step; mode 3 only
// reports. A step runs, per axis, the move multiply, the saturated add and
// then a scan of n = min(wall_count, MAX_WALLS) walls, one wall a cycle
// through the single read port of the wall memory (a registered read), and a
// final ground scan over the same port that ends early once grounded is
// set. One item is in work at a time; the result sits in an output register,
// so the next item is taken while the previous result waits, as long as the
// block is back in idle.
// Unwritten wall entries read back undefined: only scan entries written.
// Config writes are always accepted and must only happen while idle.
module aabb_axis_collision_resolve #(
  parameter int MAX_WALLS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  aacr_in_if.sink      item_in_i,
  aacr_out_if.source   item_out_o,
  aacr_cfg_if.sink     cfg_i
);

  // table index and scan counter widths
  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);

  aacr_pkg::cmd_t   cmd;
  aacr_pkg::stat_t  stat;
  aacr_pkg::item_t  item;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    scan_len;
  aacr_pkg::coord_t pos [3];
  aacr_pkg::coord_t vel [3];
  logic             gnd;

  assign cfg_i.ready = 1'b1;

  // pack the item fields for the datapath
  assign item.mode       = item_in_i.mode;
  assign item.wall_index = item_in_i.wall_index;
  assign item.wall.cx    = item_in_i.wall_center_x;
  assign item.wall.hx    = item_in_i.wall_half_x;
  assign item.wall.cy    = item_in_i.wall_center_y;
  assign item.wall.hy    = item_in_i.wall_half_y;
  assign item.wall.cz    = item_in_i.wall_center_z;
  assign item.wall.hz    = item_in_i.wall_half_z;
  assign item.vel_x      = item_in_i.vel_x;
  assign item.vel_y      = item_in_i.vel_y;
  assign item.vel_z      = item_in_i.vel_z;

  aacr_ctrl #(
    .MAX_WALLS(MAX_WALLS),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (item_in_i.valid),
    .in_mode_i  (item_in_i.mode),
    .in_ready_o (item_in_i.ready),
    .out_valid_o(item_out_o.valid),
    .out_ready_i(item_out_o.ready),
    .scan_len_i (scan_len),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  aacr_dp #(
    .MAX_WALLS(MAX_WALLS),
    .AW(AW),
    .CW(CW)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_i.valid),
    .cfg_index_i(cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .item_i     (item),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .scan_len_o (scan_len),
    .stat_o     (stat),
    .pos_o      (pos),
    .vel_o      (vel),
    .gnd_o      (gnd)
  );

  assign item_out_o.pos_x     = pos[0];
  assign item_out_o.pos_y     = pos[1];
  assign item_out_o.pos_z     = pos[2];
  assign item_out_o.out_vel_x = vel[0];
  assign item_out_o.out_vel_y = vel[1];
  assign item_out_o.out_vel_z = vel[2];
  assign item_out_o.grounded  = gnd;

endmodule

// ===== rtl/aacr_checker.sv =====
// Port-level checks of the collision resolver, bound to the top level.
// Depends on aacr_pkg and the defines header.
`include "aabb_axis_collision_resolve_defines.svh"

module aacr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input aacr_pkg::coord_t pos_x,
  input aacr_pkg::coord_t pos_y,
  input aacr_pkg::coord_t pos_z,
  input logic             grounded
);

  // a result stays up until taken, with its payload held
  `AACR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `AACR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(pos_x) && $stable(pos_y) && $stable(pos_z) && $stable(grounded))
  // one item in work at a time
  `AACR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a new result only appears after an item was in work
  `AACR_ASSERT_NOW(a_out_from_item, $rose(out_valid), $past(!in_ready))

endmodule

bind aabb_axis_collision_resolve aacr_checker u_aacr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (item_in_i.valid),
  .in_ready (item_in_i.ready),
  .out_valid(item_out_o.valid),
  .out_ready(item_out_o.ready),
  .pos_x    (item_out_o.pos_x),
  .pos_y    (item_out_o.pos_y),
  .pos_z    (item_out_o.pos_z),
  .grounded (item_out_o.grounded)
);

// ===== tb/aabb_axis_collision_resolve_test.sv =====
// Self-checking testbench of aabb_axis_collision_resolve: drives wall, place and
// step items, predicts each result in SV and compares field by field.
// Depends on aacr_pkg, the aacr_if interfaces and the RTL of the block.
`timescale 1ns / 1ps

module aabb_axis_collision_resolve_test;

  // Mode 3 is unused by the block: it only reports the position.
  localparam logic [1:0] ModeIdle = 2'd3;
  localparam int NumWalls = 64;

  typedef struct {
    aacr_pkg::coord_t px, py, pz, vx, vy, vz;
    logic   gnd;
  } box_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aacr_in_if  item_in ();
  aacr_out_if item_out ();
  aacr_cfg_if cfg ();

  aabb_axis_collision_resolve u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in_i  (item_in.sink),
    .item_out_o (item_out.source),
    .cfg_i      (cfg.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the block: config, wall table, box position.
  longint wall_c[3][NumWalls];
  longint wall_h[3][NumWalls];
  longint box_pos[3];
  longint box_half[3];
  longint scan_walls;
  longint start_pos[3];
  longint step_time;

  box_state_t expected_boxes[$];
  int  n_errors = 0;
  int  n_results = 0;
  int  n_steps = 0;
  int  n_grounded = 0;
  int  n_blocked = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;

  function automatic longint sat_pos(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit boxes_touch(longint p[3], int i);
    for (int ax = 0; ax < 3; ax++)
      if (!(abs_l(p[ax] - wall_c[ax][i]) < box_half[ax] + wall_h[ax][i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int walls_scanned();
    return scan_walls > NumWalls ? NumWalls : int'(scan_walls);
  endfunction

  function automatic box_state_t predict_box(aacr_pkg::item_t it);
    box_state_t r;
    longint vel[3];
    longint prev[3];
    longint probe[3];
    longint move, lowf, highf, np, bottom, top;
    bit gnd;
    int n;
    gnd = 1'b0;
    n = walls_scanned();
    vel = '{0, 0, 0};
    case (it.mode)
      aacr_pkg::ModeWall: begin
        wall_c[0][it.wall_index] = it.wall.cx;
        wall_c[1][it.wall_index] = it.wall.cy;
        wall_c[2][it.wall_index] = it.wall.cz;
        wall_h[0][it.wall_index] = it.wall.hx;
        wall_h[1][it.wall_index] = it.wall.hy;
        wall_h[2][it.wall_index] = it.wall.hz;
      end
      aacr_pkg::ModePlace: box_pos = start_pos;
      aacr_pkg::ModeStep: begin
        n_steps++;
        vel[0] = it.vel_x;
        vel[1] = it.vel_y;
        vel[2] = it.vel_z;
        for (int ax = 0; ax < 3; ax++) begin
          prev = box_pos;
          // arithmetic shift floors toward minus infinity
          box_pos[ax] = sat_pos(box_pos[ax] + ((vel[ax] * step_time) >>> 16));
          probe = prev;
          probe[ax] = box_pos[ax];
          move = probe[ax] - prev[ax];
          for (int i = 0; i < n; i++) begin
            if (!boxes_touch(probe, i)) continue;
            if (move == 0 && boxes_touch(prev, i)) continue;
            lowf = wall_c[ax][i] - wall_h[ax][i] - box_half[ax];
            highf = wall_c[ax][i] + wall_h[ax][i] + box_half[ax];
            if (ax == 1) begin
              // y: anything not moving up lands on the wall top
              if (move > 0) np = lowf;
              else begin
                np = highf;
                gnd = 1'b1;
              end
            end else if (move > 0) np = lowf;
            else if (move < 0) np = highf;
            else np = prev[ax] < wall_c[ax][i] ? lowf : highf;
            box_pos[ax] = sat_pos(np);
            vel[ax] = 0;
            probe[ax] = box_pos[ax];
            n_blocked++;
          end
        end
        if (!gnd) begin
          // resting contact within the tolerance band around a wall top
          bottom = box_pos[1] - box_half[1];
          for (int i = 0; i < n && !gnd; i++) begin
            top = wall_c[1][i] + wall_h[1][i];
            if (bottom < top - aacr_pkg::GroundTol || bottom > top + aacr_pkg::GroundTol)
              continue;
            if (abs_l(box_pos[0] - wall_c[0][i]) < box_half[0] + wall_h[0][i] &&
                abs_l(box_pos[2] - wall_c[2][i]) < box_half[2] + wall_h[2][i])
              gnd = 1'b1;
          end
        end
        if (gnd) n_grounded++;
      end
      default: ;
    endcase
    r.px = aacr_pkg::coord_t'(box_pos[0]);
    r.py = aacr_pkg::coord_t'(box_pos[1]);
    r.pz = aacr_pkg::coord_t'(box_pos[2]);
    r.vx = aacr_pkg::coord_t'(vel[0]);
    r.vy = aacr_pkg::coord_t'(vel[1]);
    r.vz = aacr_pkg::coord_t'(vel[2]);
    r.gnd = gnd;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  initial begin
    item_in.valid = 1'b0;
    item_in.mode = ModeIdle;
    item_in.wall_index = '0;
    item_in.wall_center_x = '0;
    item_in.wall_center_y = '0;
    item_in.wall_center_z = '0;
    item_in.wall_half_x = '0;
    item_in.wall_half_y = '0;
    item_in.wall_half_z = '0;
    item_in.vel_x = '0;
    item_in.vel_y = '0;
    item_in.vel_z = '0;
    item_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = aacr_pkg::CfgHalfX;
    cfg.data = '0;
  end

  // Receiver: stalls at random per phase; ready changes at falling edges.
  always @(negedge clk_i)
    item_out.ready = rst_ni && ($urandom_range(99) >= stall_pct);

  // Sends one item; valid stays high afterwards so the next item can follow
  // back to back. The sender gap lowers it.
  task automatic send_item(aacr_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_in.valid = 1'b0;
      @(negedge clk_i);
    end
    item_in.mode = it.mode;
    item_in.wall_index = it.wall_index;
    item_in.wall_center_x = it.wall.cx;
    item_in.wall_center_y = it.wall.cy;
    item_in.wall_center_z = it.wall.cz;
    item_in.wall_half_x = it.wall.hx;
    item_in.wall_half_y = it.wall.hy;
    item_in.wall_half_z = it.wall.hz;
    item_in.vel_x = it.vel_x;
    item_in.vel_y = it.vel_y;
    item_in.vel_z = it.vel_z;
    item_in.valid = 1'b1;
    do @(posedge clk_i); while (!item_in.ready);
    expected_boxes.push_back(predict_box(it));
    @(negedge clk_i);
  endtask

  task automatic drain();
    item_in.valid = 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Register write; only called with the block drained.
  task automatic write_reg(logic [aacr_pkg::CfgIdxBits-1:0] idx, longint value);
    cfg.index = idx;
    cfg.data = value[aacr_pkg::CoordBits-1:0];
    cfg.valid = 1'b1;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      aacr_pkg::CfgHalfX:     box_half[0] = value & 64'h7FFFFF;
      aacr_pkg::CfgHalfY:     box_half[1] = value & 64'h7FFFFF;
      aacr_pkg::CfgHalfZ:     box_half[2] = value & 64'h7FFFFF;
      aacr_pkg::CfgWallCount: scan_walls = value & 64'h7F;
      aacr_pkg::CfgStartX:    start_pos[0] = aacr_pkg::coord_t'(value);
      aacr_pkg::CfgStartY:    start_pos[1] = aacr_pkg::coord_t'(value);
      aacr_pkg::CfgStartZ:    start_pos[2] = aacr_pkg::coord_t'(value);
      default:                step_time = value & 64'hFFFF;
    endcase
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------- checker
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    box_state_t e;
    if (rst_ni && item_out.valid && item_out.ready) begin
      n_results++;
      if (expected_boxes.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual pos %0d %0d %0d",
                 $time, item_out.pos_x, item_out.pos_y, item_out.pos_z);
      end else begin
        e = expected_boxes.pop_front();
        check_field("pos_x", e.px, item_out.pos_x);
        check_field("pos_y", e.py, item_out.pos_y);
        check_field("pos_z", e.pz, item_out.pos_z);
        check_field("out_vel_x", e.vx, item_out.out_vel_x);
        check_field("out_vel_y", e.vy, item_out.out_vel_y);
        check_field("out_vel_z", e.vz, item_out.out_vel_z);
        check_field("grounded", e.gnd, item_out.grounded);
      end
    end
  end

  // ---------------------------------------------------------------- items
  function automatic aacr_pkg::item_t wall_item(int idx, longint cx, longint cy,
                                                longint cz, longint hx, longint hy,
                                                longint hz);
    aacr_pkg::item_t it;
    it = '0;
    it.mode = aacr_pkg::ModeWall;
    it.wall_index = idx[5:0];
    it.wall.cx = aacr_pkg::coord_t'(cx);
    it.wall.cy = aacr_pkg::coord_t'(cy);
    it.wall.cz = aacr_pkg::coord_t'(cz);
    it.wall.hx = aacr_pkg::half_t'(hx);
    it.wall.hy = aacr_pkg::half_t'(hy);
    it.wall.hz = aacr_pkg::half_t'(hz);
    return it;
  endfunction

  function automatic aacr_pkg::item_t step_item(longint vx, longint vy, longint vz);
    aacr_pkg::item_t it;
    it = '0;
    it.mode = aacr_pkg::ModeStep;
    it.vel_x = aacr_pkg::coord_t'(vx);
    it.vel_y = aacr_pkg::coord_t'(vy);
    it.vel_z = aacr_pkg::coord_t'(vz);
    return it;
  endfunction

  function automatic aacr_pkg::item_t mode_item(logic [1:0] m);
    aacr_pkg::item_t it;
    it = '0;
    it.mode = m;
    return it;
  endfunction

  // Mostly small numbers near the origin so boxes meet; now and then any value.
  function automatic longint near_coord(int span);
    if ($urandom_range(99) < 4) return aacr_pkg::coord_t'($urandom());
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint near_half();
    if ($urandom_range(99) < 3) return $urandom() & 32'h7FFFFF;
    return $urandom_range(0, 1024);
  endfunction

  function automatic aacr_pkg::item_t rand_wall(int idx);
    return wall_item(idx, near_coord(3000), near_coord(2000) - 800, near_coord(3000),
                     near_half(), near_half(), near_half());
  endfunction

  function automatic aacr_pkg::item_t rand_item();
    int pick;
    aacr_pkg::item_t it;
    pick = $urandom_range(99);
    if (pick < 10) return rand_wall($urandom_range(NumWalls - 1));
    if (pick < 17) return mode_item(aacr_pkg::ModePlace);
    if (pick < 20) begin
      // junk payload on the unused mode
      it = aacr_pkg::item_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom()});
      it.mode = ModeIdle;
      return it;
    end
    // gravity-like pull dominates y so the box often lands
    return step_item(near_coord(30000), near_coord(20000) - 12000, near_coord(30000));
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed_steps();
    // floor under the origin and a side wall on +x
    send_item(wall_item(0, 0, -512, 0, 4096, 256, 4096));
    send_item(wall_item(1, 1024, 512, 0, 256, 1024, 1024));
    send_item(wall_item(2, -8388608, 8388607, -8388608, 8388607, 0, 8388607));
    send_item(wall_item(3, 8388607, -8388608, 8388607, 0, 8388607, 0));
    drain();
    write_reg(aacr_pkg::CfgWallCount, 2);
    send_item(mode_item(aacr_pkg::ModePlace));
    send_item(step_item(0, 0, 0));          // resting within tolerance
    send_item(step_item(0, -6000, 0));      // falls, lands on the top face
    send_item(step_item(60000, 0, 0));      // blocked by the side wall
    send_item(step_item(-60000, 3000, 0));  // moves away, rises
    send_item(step_item(0, 60000, 0));      // rises clear of the side wall
    send_item(step_item(8388607, 8388607, 8388607));     // saturates high
    send_item(step_item(-8388608, -8388608, -8388608));  // saturates low
    send_item(mode_item(ModeIdle));
    send_item(step_item(-1, -1, -1));       // floor rounding of tiny moves
    drain();
    write_reg(aacr_pkg::CfgStartX, 8388607);
    write_reg(aacr_pkg::CfgStartY, -8388608);
    write_reg(aacr_pkg::CfgStartZ, -8388608);
    send_item(mode_item(aacr_pkg::ModePlace));
    send_item(step_item(8388607, -8388608, 1));
    drain();
    write_reg(aacr_pkg::CfgStartX, 0);
    write_reg(aacr_pkg::CfgStartY, 0);
    write_reg(aacr_pkg::CfgStartZ, 0);
    write_reg(aacr_pkg::CfgWallCount, 4);
    send_item(mode_item(aacr_pkg::ModePlace));
    send_item(step_item(1000, -1000, 1000));
  endtask

  task automatic fill_wall_table();
    for (int i = 0; i < NumWalls; i++) send_item(rand_wall(i));
  endtask

  task automatic test_config_extremes();
    drain();
    write_reg(aacr_pkg::CfgWallCount, 127);  // above the table: scans all entries
    write_reg(aacr_pkg::CfgFrameTime, 65535);
    write_reg(aacr_pkg::CfgHalfX, 0);
    write_reg(aacr_pkg::CfgHalfY, 8388607);
    write_reg(aacr_pkg::CfgHalfZ, 0);
    send_item(mode_item(aacr_pkg::ModePlace));
    repeat (6) send_item(rand_item());
    drain();
    write_reg(aacr_pkg::CfgFrameTime, 0);
    write_reg(aacr_pkg::CfgHalfX, 8388607);
    write_reg(aacr_pkg::CfgHalfY, 0);
    write_reg(aacr_pkg::CfgHalfZ, 8388607);
    repeat (6) send_item(rand_item());
    drain();
    write_reg(aacr_pkg::CfgHalfX, aacr_pkg::HalfXReset);
    write_reg(aacr_pkg::CfgHalfY, aacr_pkg::HalfYReset);
    write_reg(aacr_pkg::CfgHalfZ, aacr_pkg::HalfZReset);
    write_reg(aacr_pkg::CfgFrameTime, aacr_pkg::FrameTimeReset);
  endtask

  task automatic test_random_phase(int gap_pct, int hold_pct, int n_items);
    drain();
    idle_pct = gap_pct;
    stall_pct = hold_pct;
    // fresh setting per phase, mostly few walls so steps stay short
    write_reg(aacr_pkg::CfgWallCount, $urandom_range(99) < 30 ? 64 : $urandom_range(0, 12));
    write_reg(aacr_pkg::CfgFrameTime, $urandom_range(500, 4000));
    write_reg(aacr_pkg::CfgHalfX, $urandom_range(32, 512));
    write_reg(aacr_pkg::CfgHalfY, $urandom_range(32, 512));
    write_reg(aacr_pkg::CfgHalfZ, $urandom_range(32, 512));
    write_reg(aacr_pkg::CfgStartX, near_coord(1000));
    write_reg(aacr_pkg::CfgStartY, near_coord(1000) + 1200);
    write_reg(aacr_pkg::CfgStartZ, near_coord(1000));
    send_item(mode_item(aacr_pkg::ModePlace));
    for (int i = 0; i < n_items; i++) send_item(rand_item());
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    box_pos = '{0, 0, 0};
    start_pos = '{0, 0, 0};
    box_half = '{aacr_pkg::HalfXReset, aacr_pkg::HalfYReset, aacr_pkg::HalfZReset};
    scan_walls = 0;
    step_time = aacr_pkg::FrameTimeReset;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_steps();
    fill_wall_table();
    test_config_extremes();
    test_random_phase(0, 0, 200);
    test_random_phase(62, 0, 190);
    test_random_phase(0, 62, 190);
    test_random_phase(30, 30, 190);
    test_random_phase(0, 0, 60);
    drain();
    repeat (300) @(negedge clk_i);

    $display("Covered %0d results, %0d steps, %0d blocked contacts, %0d grounded steps,",
             n_results, n_steps, n_blocked, n_grounded);
    $display("over wall count, half extent and frame time extremes and four idle mixes.");
    if (n_errors == 0 && expected_boxes.size() == 0) begin
      $display("aabb_axis_collision_resolve_test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, expected_boxes.size());
      $display("aabb_axis_collision_resolve_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #50ms;
    $display("timeout with %0d results outstanding", expected_boxes.size());
    $display("aabb_axis_collision_resolve_test: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/aacr_pkg.sv
rtl/aacr_if.sv
rtl/aacr_ctrl.sv
rtl/aacr_dp.sv
rtl/aabb_axis_collision_resolve.sv
rtl/aacr_checker.sv
tb/aabb_axis_collision_resolve_test.sv
